[rtl/core/assert_macros.svh]
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold on every clock edge out of reset
`define SSQ_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error(msg);

// antecedent on one edge implies consequent on the next edge
`define SSQ_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error(msg);

`endif

[rtl/core/ssq_pkg.sv]
// shared types, codes and defaults of the sorted event queue
package ssq_pkg;

    // default sizes
    localparam int DEPTH_DEF        = 64;
    localparam int KEY_BITS_DEF     = 32;
    localparam int PAYLOAD_BITS_DEF = 32;

    // fixed port field widths
    localparam int KEY_W   = 32;
    localparam int PAY_W   = 32;
    localparam int COUNT_W = 7;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_POP_EMPTY = 2'd1,
        ST_PUSH_FULL = 2'd2
    } t_status;

    // shift commands broadcast to every cell
    typedef struct packed {
        logic push;
        logic pop;
    } t_cell_ctrl;

    // one result beat
    typedef struct packed {
        t_status              status;
        logic signed [KEY_W-1:0] out_key;
        logic [PAY_W-1:0]     out_payload;
        logic [COUNT_W-1:0]   entry_count;
        logic                 queue_empty;
    } t_result;

endpackage

[rtl/core/stable_sorted_event_queue.sv]
// sorted event queue top: chain of entry cells, occupancy count, output skid
// result beats are registered in the output register, or in the skid when it is held
// one push or pop per cycle when not stalled; every cell compares and shifts at once
// output stage is a main register plus a skid register, so input keeps flowing
// while one result waits; input stalls only when both are full
// reset (synchronous, active low) empties the queue and the output stage
module stable_sorted_event_queue #(
    parameter int DEPTH        = ssq_pkg::DEPTH_DEF,
    parameter int KEY_BITS     = ssq_pkg::KEY_BITS_DEF,
    parameter int PAYLOAD_BITS = ssq_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_operation,
    input  logic signed [ssq_pkg::KEY_W-1:0] i_key,
    input  logic [ssq_pkg::PAY_W-1:0]       i_payload,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [1:0]                      o_status,
    output logic signed [ssq_pkg::KEY_W-1:0] o_out_key,
    output logic [ssq_pkg::PAY_W-1:0]       o_out_payload,
    output logic [ssq_pkg::COUNT_W-1:0]     o_entry_count,
    output logic                            o_queue_empty
);
    import ssq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic signed [KEY_BITS-1:0] cell_key   [DEPTH];
    logic [PAYLOAD_BITS-1:0]    cell_pay   [DEPTH];
    logic                       cell_holds [DEPTH];

    logic [CNT_W-1:0]           r_count, n_count;
    logic                       accept, is_pop, is_full, is_empty;
    t_cell_ctrl                 ctrl;
    logic signed [KEY_BITS-1:0] new_key;
    logic [PAYLOAD_BITS-1:0]    new_pay;
    logic signed [KEY_BITS-1:0] head_key;
    logic [PAYLOAD_BITS-1:0]    head_pay;
    t_result                    res;

    logic                       r_out_valid, r_skid_valid;
    t_result                    r_out, r_skid;
    logic                       out_take;

    // input beat decode
    assign accept   = i_in_valid && !o_in_stall;
    assign is_pop   = (t_op'(i_operation) == OP_POP);
    assign is_full  = (r_count == CNT_W'(DEPTH));
    assign is_empty = (r_count == '0);
    assign new_key  = KEY_BITS'(i_key);
    assign new_pay  = PAYLOAD_BITS'(i_payload);

    assign ctrl.push = accept && !is_pop && !is_full;
    assign ctrl.pop  = accept && is_pop && !is_empty;

    // row of cells
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic                       left_holds;
        logic signed [KEY_BITS-1:0] left_key, right_key;
        logic [PAYLOAD_BITS-1:0]    left_pay, right_pay;

        if (g == 0) begin : g_first
            assign left_holds = 1'b1;
            assign left_key   = '0;
            assign left_pay   = '0;
        end else begin : g_mid
            assign left_holds = cell_holds[g-1];
            assign left_key   = cell_key[g-1];
            assign left_pay   = cell_pay[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign right_key = '0;
            assign right_pay = '0;
        end else begin : g_inner
            assign right_key = cell_key[g+1];
            assign right_pay = cell_pay[g+1];
        end

        ssq_cell #(
            .DEPTH        (DEPTH),
            .KEY_BITS     (KEY_BITS),
            .PAYLOAD_BITS (PAYLOAD_BITS),
            .INDEX        (g)
        ) u_cell (
            .i_clk           (i_clk),
            .i_ctrl          (ctrl),
            .i_count         (r_count),
            .i_new_key       (new_key),
            .i_new_payload   (new_pay),
            .i_left_holds    (left_holds),
            .i_left_key      (left_key),
            .i_left_payload  (left_pay),
            .i_right_key     (right_key),
            .i_right_payload (right_pay),
            .o_key           (cell_key[g]),
            .o_payload       (cell_pay[g]),
            .o_holds         (cell_holds[g])
        );
    end

    // occupancy count
    always_comb begin
        n_count = r_count;
        if (ctrl.push) begin
            n_count = r_count + CNT_W'(1);
        end else if (ctrl.pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // head before a pop, after a push: new entry lands in front unless cell 0 holds
    always_comb begin
        head_key = '0;
        head_pay = '0;
        res.status = ST_OK;
        if (is_pop) begin
            if (is_empty) begin
                res.status = ST_POP_EMPTY;
            end else begin
                head_key = cell_key[0];
                head_pay = cell_pay[0];
            end
        end else if (is_full) begin
            res.status = ST_PUSH_FULL;
            head_key   = cell_key[0];
            head_pay   = cell_pay[0];
        end else if (cell_holds[0]) begin
            head_key = cell_key[0];
            head_pay = cell_pay[0];
        end else begin
            head_key = new_key;
            head_pay = new_pay;
        end
        res.out_key     = KEY_W'(head_key);
        res.out_payload = PAY_W'(head_pay);
        res.entry_count = COUNT_W'(n_count);
        res.queue_empty = (n_count == '0);
    end

    // output register with skid stage
    assign out_take   = r_out_valid && !i_out_stall;
    assign o_in_stall = r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || out_take) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= accept;
            end
        end else if (accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_take) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (accept) begin
                r_out <= res;
            end
        end else if (accept) begin
            r_skid <= res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out.status;
    assign o_out_key     = r_out.out_key;
    assign o_out_payload = r_out.out_payload;
    assign o_entry_count = r_out.entry_count;
    assign o_queue_empty = r_out.queue_empty;

endmodule

[rtl/core/ssq_cell.sv]
// one slot of the sorted chain: holds an entry and shifts with its neighbours
module ssq_cell #(
    parameter int DEPTH        = ssq_pkg::DEPTH_DEF,
    parameter int KEY_BITS     = ssq_pkg::KEY_BITS_DEF,
    parameter int PAYLOAD_BITS = ssq_pkg::PAYLOAD_BITS_DEF,
    parameter int INDEX        = 0
) (
    input  logic                             i_clk,
    input  ssq_pkg::t_cell_ctrl              i_ctrl,
    input  logic [$clog2(DEPTH+1)-1:0]       i_count,
    input  logic signed [KEY_BITS-1:0]       i_new_key,
    input  logic [PAYLOAD_BITS-1:0]          i_new_payload,
    input  logic                             i_left_holds,
    input  logic signed [KEY_BITS-1:0]       i_left_key,
    input  logic [PAYLOAD_BITS-1:0]          i_left_payload,
    input  logic signed [KEY_BITS-1:0]       i_right_key,
    input  logic [PAYLOAD_BITS-1:0]          i_right_payload,
    output logic signed [KEY_BITS-1:0]       o_key,
    output logic [PAYLOAD_BITS-1:0]          o_payload,
    output logic                             o_holds
);
    import ssq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic signed [KEY_BITS-1:0] r_key, n_key;
    logic [PAYLOAD_BITS-1:0]    r_payload, n_payload;
    logic                       occupied;

    // entry stays put when it is live and not larger than the new key
    assign occupied = i_count > CNT_W'(INDEX);
    assign o_holds  = occupied && (r_key <= i_new_key);

    // next entry: keep, take the new one, shift right on push, shift left on pop
    always_comb begin
        n_key     = r_key;
        n_payload = r_payload;
        if (i_ctrl.push) begin
            if (!o_holds) begin
                if (i_left_holds) begin
                    n_key     = i_new_key;
                    n_payload = i_new_payload;
                end else begin
                    n_key     = i_left_key;
                    n_payload = i_left_payload;
                end
            end
        end else if (i_ctrl.pop) begin
            n_key     = i_right_key;
            n_payload = i_right_payload;
        end
    end

    // entry storage, no reset: slots at or above the count are never shown
    always_ff @(posedge i_clk) begin
        r_key     <= n_key;
        r_payload <= n_payload;
    end

    assign o_key     = r_key;
    assign o_payload = r_payload;

endmodule

[rtl/core/ssq_checker.sv]
// port-level checks on the sorted event queue, bound to the top level
`include "assert_macros.svh"

module ssq_checker #(
    parameter int DEPTH = ssq_pkg::DEPTH_DEF
) (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             o_out_valid,
    input logic                             i_out_stall,
    input logic [1:0]                       o_status,
    input logic [ssq_pkg::PAY_W-1:0]        o_out_payload,
    input logic [ssq_pkg::COUNT_W-1:0]      o_entry_count,
    input logic                             o_queue_empty
);
    import ssq_pkg::*;

    logic beat_valid;
    assign beat_valid = o_out_valid;

    // empty flag agrees with the reported count
    `SSQ_ASSERT_ALWAYS(a_empty_flag, i_clk, i_rst_n,
        !beat_valid || (o_queue_empty == (o_entry_count == '0)), "empty flag mismatch")

    // a pop on an empty queue leaves it empty with a zero payload
    `SSQ_ASSERT_ALWAYS(a_pop_empty, i_clk, i_rst_n,
        !(beat_valid && o_status == ST_POP_EMPTY) || (o_queue_empty && o_out_payload == '0),
        "failed pop reports a non-empty queue")

    // a dropped push only happens with the queue full
    `SSQ_ASSERT_ALWAYS(a_push_full, i_clk, i_rst_n,
        !(beat_valid && o_status == ST_PUSH_FULL) ||
        (o_entry_count == COUNT_W'(DEPTH)), "push dropped below full")

    // status never carries the unused code
    `SSQ_ASSERT_ALWAYS(a_status_code, i_clk, i_rst_n,
        !beat_valid || o_status == ST_OK || o_status == ST_POP_EMPTY ||
        o_status == ST_PUSH_FULL, "undefined status code")

    // a stalled result beat stays valid with its payload and count unchanged
    `SSQ_ASSERT_ALWAYS(a_out_hold, i_clk, i_rst_n,
        !($past(o_out_valid && i_out_stall)) ||
        (o_out_valid && $stable(o_out_payload) && $stable(o_entry_count)),
        "stalled result beat changed")

endmodule

bind stable_sorted_event_queue ssq_checker #(.DEPTH(DEPTH)) u_ssq_checker (.*);

[tb/testbench.sv]
// self-checking testbench of the stable sorted event queue
`timescale 1ns / 1ps

module testbench;

    import ssq_pkg::*;

    localparam int QUEUE_DEPTH  = DEPTH_DEF;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int SETTLE_BEATS = 8;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_stall;
    logic                    i_operation = 1'b0;
    logic signed [KEY_W-1:0] i_key = '0;
    logic [PAY_W-1:0]        i_payload = '0;
    logic                    o_out_valid;
    logic                    i_out_stall = 1'b0;
    logic [1:0]              o_status;
    logic signed [KEY_W-1:0] o_out_key;
    logic [PAY_W-1:0]        o_out_payload;
    logic [COUNT_W-1:0]      o_entry_count;
    logic                    o_queue_empty;

    // shadow of the queue contents, ascending key, ties in arrival order
    logic signed [KEY_W-1:0] held_keys[$];
    logic [PAY_W-1:0]        held_payloads[$];
    // reports predicted for accepted beats, oldest first
    t_result                 queue_reports[$];

    int  error_count = 0;
    int  cycle_count = 0;
    bit  tx_idle_en = 1'b0;
    bit  rx_idle_en = 1'b0;
    int  hold_token = 0;
    int  hold_seen = 0;
    int  hold_left = 0;
    int  rx_gap_left = 0;

    stable_sorted_event_queue uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_operation   (i_operation),
        .i_key         (i_key),
        .i_payload     (i_payload),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_out_key     (o_out_key),
        .o_out_payload (o_out_payload),
        .o_entry_count (o_entry_count),
        .o_queue_empty (o_queue_empty)
    );

    // clock
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // apply one operation to the shadow queue and return the report it gives
    function automatic t_result next_queue_report(t_op op, logic signed [KEY_W-1:0] key,
                                                  logic [PAY_W-1:0] payload);
        t_result rep;
        int      pos;
        bit      popped;
        rep = '0;
        rep.status = ST_OK;
        popped = 1'b0;
        if (op == OP_PUSH) begin
            if (held_keys.size() >= QUEUE_DEPTH) begin
                rep.status = ST_PUSH_FULL;
            end else begin
                // new entry goes behind every entry with a key not above its own
                pos = 0;
                while (pos < held_keys.size() && held_keys[pos] <= key) pos++;
                held_keys.insert(pos, key);
                held_payloads.insert(pos, payload);
            end
        end else begin
            if (held_keys.size() == 0) begin
                rep.status = ST_POP_EMPTY;
            end else begin
                rep.out_key = held_keys.pop_front();
                rep.out_payload = held_payloads.pop_front();
                popped = 1'b1;
            end
        end
        // otherwise report the head, or zeros when nothing is held
        if (!popped && rep.status != ST_POP_EMPTY && held_keys.size() > 0) begin
            rep.out_key = held_keys[0];
            rep.out_payload = held_payloads[0];
        end
        rep.entry_count = COUNT_W'(held_keys.size());
        rep.queue_empty = (held_keys.size() == 0);
        return rep;
    endfunction

    // keys: full range, a narrow band full of ties, multiples of 2^16, the extremes
    function automatic logic signed [KEY_W-1:0] pick_key();
        logic signed [KEY_W-1:0] k;
        case ($urandom_range(0, 4))
            0: k = $signed(KEY_W'($urandom_range(0, 8))) - 4;
            1: begin
                case ($urandom_range(0, 3))
                    0: k = 32'sh8000_0000;
                    1: k = 32'sh7fff_ffff;
                    2: k = '0;
                    default: k = -1;
                endcase
            end
            2: k = $signed(KEY_W'($urandom_range(0, 15))) <<< 16;
            default: k = $signed($urandom());
        endcase
        return k;
    endfunction

    // offer one beat, predict it on acceptance, then maybe leave a gap
    task automatic send_beat(t_op op, logic signed [KEY_W-1:0] key, logic [PAY_W-1:0] payload);
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_key       <= key;
        i_payload   <= payload;
        do @(posedge i_clk); while (o_in_stall);
        queue_reports.push_back(next_queue_report(op, key, payload));
        if (tx_idle_en && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    // random beat with the given chance of a push in percent
    task automatic send_random(int push_pct);
        t_op op;
        if ($urandom_range(0, 99) < push_pct) op = OP_PUSH;
        else op = OP_POP;
        send_beat(op, pick_key(), $urandom());
    endtask

    // stop offering and wait for every predicted report
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (queue_reports.size() != 0) @(posedge i_clk);
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            if (queue_reports.size() == 0) begin
                $error("result beat with no report pending");
                error_count++;
            end else begin
                want = queue_reports.pop_front();
                if (o_status !== want.status) begin
                    $error("status expected %0d got %0d", want.status, o_status);
                    error_count++;
                end
                if (o_out_key !== want.out_key) begin
                    $error("out_key expected %0d got %0d", want.out_key, o_out_key);
                    error_count++;
                end
                if (o_out_payload !== want.out_payload) begin
                    $error("out_payload expected %h got %h", want.out_payload, o_out_payload);
                    error_count++;
                end
                if (o_entry_count !== want.entry_count) begin
                    $error("entry_count expected %0d got %0d", want.entry_count, o_entry_count);
                    error_count++;
                end
                if (o_queue_empty !== want.queue_empty) begin
                    $error("queue_empty expected %0d got %0d", want.queue_empty, o_queue_empty);
                    error_count++;
                end
            end
        end
    end

    // receiver: long hold-off on request, otherwise random stall bursts
    always @(posedge i_clk) begin
        if (hold_token != hold_seen) begin
            hold_seen = hold_token;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (rx_gap_left > 0) begin
            rx_gap_left--;
            i_out_stall <= 1'b1;
        end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
            rx_gap_left = $urandom_range(0, 11);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // extremes, ties, ordering and pops on an empty queue, no idling
    task automatic test_directed();
        send_beat(OP_POP, 32'sh1234_5678, 32'hdead_beef);
        send_beat(OP_PUSH, 32'sh7fff_ffff, 32'hffff_ffff);
        send_beat(OP_PUSH, 32'sh8000_0000, 32'h0000_0000);
        send_beat(OP_PUSH, 32'sh0000_0000, 32'haaaa_aaaa);
        send_beat(OP_PUSH, -32'sd1, 32'h5555_5555);
        send_beat(OP_PUSH, 32'sh0000_0000, 32'h0000_0001);
        send_beat(OP_PUSH, 32'sh0001_0000, 32'h0000_0002);
        send_beat(OP_PUSH, 32'sh0000_0000, 32'h0000_0003);
        send_beat(OP_PUSH, 32'sh7fff_ffff, 32'h1234_5678);
        send_beat(OP_PUSH, 32'sh8000_0000, 32'hffff_ffff);
        repeat (10) send_beat(OP_POP, '0, '0);
        send_beat(OP_POP, -32'sd1, 32'hffff_ffff);
        send_beat(OP_PUSH, -32'sd1, 32'h8000_0001);
        send_beat(OP_POP, '0, '0);
        wait_drained();
    endtask

    // fill to the limit, push into a full queue, then empty it completely
    task automatic test_fill_and_drain();
        tx_idle_en = 1'b1;
        rx_idle_en <= 1'b1;
        while (held_keys.size() < QUEUE_DEPTH) send_beat(OP_PUSH, pick_key(), $urandom());
        repeat (3) send_beat(OP_PUSH, pick_key(), $urandom());
        repeat (QUEUE_DEPTH + 2) send_beat(OP_POP, pick_key(), $urandom());
        wait_drained();
    endtask

    // receiver holds off while beats keep coming, then sender waits for all
    task automatic test_backpressure();
        tx_idle_en = 1'b0;
        hold_token <= hold_token + 1;
        repeat (60) send_random(60);
        wait_drained();
    endtask

    // random segments of varying push bias, idling switched per segment
    task automatic test_random();
        int left;
        int seg;
        int bias;
        left = 1550;
        while (left > 0) begin
            seg = $urandom_range(20, 120);
            if (seg > left) seg = left;
            case ($urandom_range(0, 3))
                0: bias = 85;
                1: bias = 25;
                default: bias = 55;
            endcase
            tx_idle_en = ($urandom_range(0, 3) != 0);
            rx_idle_en <= ($urandom_range(0, 3) != 0);
            repeat (seg) send_random(bias);
            left -= seg;
        end
    endtask

    // closing stretch at full rate with no idling on either side
    task automatic test_full_rate();
        tx_idle_en = 1'b0;
        rx_idle_en <= 1'b0;
        repeat (80) send_random(80);
        repeat (40) send_random(30);
    endtask

    // sequence
    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_fill_and_drain();
        test_backpressure();
        test_random();
        test_full_rate();
        wait_drained();
        repeat (SETTLE_BEATS) @(posedge i_clk);
        if (error_count == 0 && queue_reports.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/ssq_pkg.sv
rtl/core/ssq_cell.sv
rtl/core/stable_sorted_event_queue.sv
rtl/core/ssq_checker.sv
tb/testbench.sv
